// ----- src/tlbn_pkg.sv -----
// Shared types and constants for the NRU-refill TLB.
// Depends on nothing; every other file in src imports it.
package tlbn_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned PpnW   = 25;
  localparam int unsigned SizeW  = 3;
  localparam int unsigned FslotW = 2;

  typedef enum logic [1:0] {
    ACT_TRANSLATE = 2'd0,
    ACT_REFILL    = 2'd1,
    ACT_CLEAR_USE = 2'd2,
    ACT_NONE      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ALIGN = 2'd1,
    ST_MISS  = 2'd2,
    ST_RO    = 2'd3
  } status_e;

  localparam logic [SizeW-1:0] SizeWord = 3'd4;
  localparam logic [SizeW-1:0] SizeHalf = 3'd2;

endpackage

// ----- src/tlb_translate_nru_refill_unit.sv -----
// Top level of the fully associative TLB with NRU refill.
// Depends on tlbn_pkg, tlbn_lookup and tlbn_victim.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one request per
// transfer: a translate, a refill that supplies the missing entry and finishes
// the access, or a clear of all use bits. The output channel (out_valid_o /
// out_stall_i) returns exactly one result per request, in request order.
// A request taken from the input channel sits in the input register, is
// processed by the tag compare, victim choice and status logic, and its result
// is loaded into the output register, which drives out_valid_o. Throughput is
// one request per cycle while the receiver does not stall; the single
// combinational pass between the input register and the output register,
// which also updates the slot state, sets that figure, so each request sees
// every state change of the request before it.
// When the receiver stalls with a result held, the input register keeps its
// request and in_stall_o is raised; state is only updated when a result moves
// into the output register. Reset clears the valid, use and dirty bits, the
// hit counter and the valid flags of both pipeline registers; tags, page
// numbers and read-only bits are loaded on refill and need no reset.
module tlb_translate_nru_refill_unit #(
  parameter int unsigned TLB_ENTRIES = 4,
  parameter int unsigned PAGE_BITS   = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      action_i,
  input  logic [tlbn_pkg::AddrW-1:0]      virt_addr_i,
  input  logic [tlbn_pkg::SizeW-1:0]      access_size_i,
  input  logic                            is_write_i,
  input  logic [tlbn_pkg::PpnW-1:0]       fill_ppn_i,
  input  logic                            fill_read_only_i,
  input  logic                            fill_dirty_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [tlbn_pkg::AddrW-1:0]      phys_addr_o,
  output logic [tlbn_pkg::FslotW-1:0]     fill_slot_o,
  output logic [tlbn_pkg::AddrW-1:0]      hits_o
);
  import tlbn_pkg::*;

  localparam int unsigned IdxW = $clog2(TLB_ENTRIES);
  localparam int unsigned VpnW = AddrW - PAGE_BITS;

  // Input register.
  logic              in_valid_q;
  action_e           action_q;
  logic [AddrW-1:0]  va_q;
  logic [SizeW-1:0]  size_q;
  logic              wr_q;
  logic [PpnW-1:0]   fppn_q;
  logic              fro_q;
  logic              fdirty_q;

  // Slot state.
  logic [TLB_ENTRIES-1:0]           valid_q, valid_d;
  logic [TLB_ENTRIES-1:0]           use_q, use_d;
  logic [TLB_ENTRIES-1:0]           dirty_q, dirty_d;
  logic [TLB_ENTRIES-1:0][VpnW-1:0] vpn_q;
  logic [TLB_ENTRIES-1:0][PpnW-1:0] ppn_q;
  logic [TLB_ENTRIES-1:0]           ro_q;
  logic [AddrW-1:0]                 hit_cnt_q, hit_cnt_d;

  // Output register.
  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [AddrW-1:0]  phys_q, phys_d;
  logic [FslotW-1:0] fslot_q, fslot_d;
  logic [AddrW-1:0]  hits_q;

  logic            out_ready, advance, in_accept, do_fill;
  logic [VpnW-1:0] vpn;
  logic [PAGE_BITS-1:0] offset;
  logic            misaligned, hit;
  logic [IdxW-1:0] hit_idx, victim_idx;
  logic [PpnW-1:0] sel_ppn;
  logic [PpnW+PAGE_BITS+AddrW-1:0] phys_wide;
  logic [IdxW+FslotW-1:0] slot_ext;

  // The output register can take a result when empty or being drained.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign vpn    = va_q[AddrW-1:PAGE_BITS];
  assign offset = va_q[PAGE_BITS-1:0];

  tlbn_lookup #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_lookup (
    .slot_valid_i(valid_q),
    .slot_vpn_i  (vpn_q),
    .vpn_i       (vpn),
    .hit_o       (hit),
    .hit_idx_o   (hit_idx)
  );

  tlbn_victim #(
    .TLB_ENTRIES(TLB_ENTRIES)
  ) u_victim (
    .slot_valid_i(valid_q),
    .slot_use_i  (use_q),
    .slot_dirty_i(dirty_q),
    .victim_idx_o(victim_idx)
  );

  // Only word and halfword accesses have alignment requirements.
  assign misaligned = ((size_q == SizeWord) && (va_q[1:0] != 2'b00)) ||
                      ((size_q == SizeHalf) && va_q[0]);

  always_comb begin
    valid_d   = valid_q;
    use_d     = use_q;
    dirty_d   = dirty_q;
    hit_cnt_d = hit_cnt_q;
    status_d  = ST_OK;
    phys_d    = '0;
    fslot_d   = '0;
    do_fill   = 1'b0;
    sel_ppn   = ppn_q[hit_idx];
    slot_ext  = {{FslotW{1'b0}}, victim_idx};

    unique case (action_q)
      ACT_CLEAR_USE: begin
        use_d = '0;
      end
      ACT_TRANSLATE: begin
        if (misaligned) begin
          status_d = ST_ALIGN;
        end else if (!hit) begin
          status_d = ST_MISS;
        end else begin
          // A hit is counted even when the write permission check fails.
          hit_cnt_d = hit_cnt_q + AddrW'(1);
          if (ro_q[hit_idx] && wr_q) begin
            status_d = ST_RO;
          end else begin
            use_d[hit_idx] = 1'b1;
            if (wr_q) begin
              dirty_d[hit_idx] = 1'b1;
            end
          end
        end
      end
      ACT_REFILL: begin
        sel_ppn = fppn_q;
        if (misaligned) begin
          status_d = ST_ALIGN;
        end else if (fro_q && wr_q) begin
          status_d = ST_RO;
        end else begin
          do_fill             = 1'b1;
          valid_d[victim_idx] = 1'b1;
          use_d[victim_idx]   = 1'b1;
          dirty_d[victim_idx] = fdirty_q || wr_q;
          fslot_d             = slot_ext[FslotW-1:0];
        end
      end
      default: begin
      end
    endcase

    phys_wide = {{AddrW{1'b0}}, sel_ppn, offset};
    if (status_d == ST_OK && action_q != ACT_CLEAR_USE && action_q != ACT_NONE) begin
      phys_d = phys_wide[AddrW-1:0];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      use_q       <= '0;
      dirty_q     <= '0;
      hit_cnt_q   <= '0;
    end else begin
      if (!in_valid_q || advance) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        valid_q   <= valid_d;
        use_q     <= use_d;
        dirty_q   <= dirty_d;
        hit_cnt_q <= hit_cnt_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q <= action_e'(action_i);
      va_q     <= virt_addr_i;
      size_q   <= access_size_i;
      wr_q     <= is_write_i;
      fppn_q   <= fill_ppn_i;
      fro_q    <= fill_read_only_i;
      fdirty_q <= fill_dirty_i;
    end
    if (advance) begin
      status_q <= status_d;
      phys_q   <= phys_d;
      fslot_q  <= fslot_d;
      hits_q   <= hit_cnt_d;
      if (do_fill) begin
        vpn_q[victim_idx] <= vpn;
        ppn_q[victim_idx] <= fppn_q;
        ro_q[victim_idx]  <= fro_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign phys_addr_o = phys_q;
  assign fill_slot_o = fslot_q;
  assign hits_o      = hits_q;

endmodule

// ----- src/tlbn_lookup.sv -----
// Associative tag compare over all TLB slots with a lowest-slot-wins priority encode.
// Depends on tlbn_pkg.
module tlbn_lookup #(
  parameter int unsigned TLB_ENTRIES = 4,
  parameter int unsigned PAGE_BITS   = 7,
  localparam int unsigned IdxW = $clog2(TLB_ENTRIES),
  localparam int unsigned VpnW = tlbn_pkg::AddrW - PAGE_BITS
) (
  input  logic [TLB_ENTRIES-1:0]           slot_valid_i,
  input  logic [TLB_ENTRIES-1:0][VpnW-1:0] slot_vpn_i,
  input  logic [VpnW-1:0]                  vpn_i,
  output logic                             hit_o,
  output logic [IdxW-1:0]                  hit_idx_o
);
  import tlbn_pkg::*;

  logic [TLB_ENTRIES-1:0] match;

  always_comb begin
    hit_idx_o = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      match[i] = slot_valid_i[i] && (slot_vpn_i[i] == vpn_i);
      if (match[i]) begin
        hit_idx_o = IdxW'(i);
      end
    end
    hit_o = |match;
  end

endmodule

// ----- src/tlbn_victim.sv -----
// Refill slot choice: lowest invalid slot, else lowest slot of the lowest
// not-recently-used class (use * 2 + dirty). Depends on tlbn_pkg.
module tlbn_victim #(
  parameter int unsigned TLB_ENTRIES = 4,
  localparam int unsigned IdxW = $clog2(TLB_ENTRIES)
) (
  input  logic [TLB_ENTRIES-1:0] slot_valid_i,
  input  logic [TLB_ENTRIES-1:0] slot_use_i,
  input  logic [TLB_ENTRIES-1:0] slot_dirty_i,
  output logic [IdxW-1:0]        victim_idx_o
);
  import tlbn_pkg::*;

  logic [TLB_ENTRIES-1:0] cls0, cls1, cls2, cls3, cand;

  always_comb begin
    cls0 = ~slot_use_i & ~slot_dirty_i;
    cls1 = ~slot_use_i &  slot_dirty_i;
    cls2 =  slot_use_i & ~slot_dirty_i;
    cls3 =  slot_use_i &  slot_dirty_i;
    priority if (|(~slot_valid_i)) begin
      cand = ~slot_valid_i;
    end else if (|cls0) begin
      cand = cls0;
    end else if (|cls1) begin
      cand = cls1;
    end else if (|cls2) begin
      cand = cls2;
    end else begin
      cand = cls3;
    end
    victim_idx_o = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        victim_idx_o = IdxW'(i);
      end
    end
  end

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the NRU-refill TLB: directed table, then random traffic.
// Depends on tlbn_pkg and tlb_translate_nru_refill_unit in src; it reads no files.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlbn_pkg::*;

  localparam int unsigned Entries     = 4;
  localparam int unsigned PageBits    = 7;
  localparam int unsigned VpnW        = AddrW - PageBits;
  localparam int unsigned RandomItems = 800;
  localparam int unsigned PoolSize    = 6;
  localparam int unsigned QuietLimit  = 1000;

  typedef struct packed {
    action_e            action;
    logic [AddrW-1:0]   vaddr;
    logic [SizeW-1:0]   size;
    logic               wr;
    logic [PpnW-1:0]    ppn;
    logic               ro;
    logic               dirty;
  } tlb_req_t;

  typedef struct packed {
    status_e            status;
    logic [AddrW-1:0]   paddr;
    logic [FslotW-1:0]  slot;
    logic [AddrW-1:0]   hits;
  } tlb_rsp_t;

  typedef struct {
    tlb_req_t req;
    bit       typed;
    tlb_rsp_t rsp;
  } dir_row_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic [1:0]          action_i         = '0;
  logic [AddrW-1:0]    virt_addr_i      = '0;
  logic [SizeW-1:0]    access_size_i    = '0;
  logic                is_write_i       = 1'b0;
  logic [PpnW-1:0]     fill_ppn_i       = '0;
  logic                fill_read_only_i = 1'b0;
  logic                fill_dirty_i     = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic [1:0]          status_o;
  logic [AddrW-1:0]    phys_addr_o;
  logic [FslotW-1:0]   fill_slot_o;
  logic [AddrW-1:0]    hits_o;

  // Shadow copy of the translation slots and the hit counter.
  logic                slot_valid [Entries];
  logic [VpnW-1:0]     slot_vpn   [Entries];
  logic [PpnW-1:0]     slot_ppn   [Entries];
  logic                slot_ro    [Entries];
  logic                slot_use   [Entries];
  logic                slot_dirty [Entries];
  logic [AddrW-1:0]    hit_total;

  tlb_rsp_t            predicted_results [$];
  dir_row_t            dir_rows [$];
  logic [VpnW-1:0]     page_pool [PoolSize];

  bit                  calm;
  int unsigned         fail_count;
  int unsigned         n_sent;
  int unsigned         n_checked;
  int unsigned         quiet_cycles;
  int unsigned         status_seen [4];

  tlb_translate_nru_refill_unit #(
    .TLB_ENTRIES(Entries),
    .PAGE_BITS  (PageBits)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .virt_addr_i     (virt_addr_i),
    .access_size_i   (access_size_i),
    .is_write_i      (is_write_i),
    .fill_ppn_i      (fill_ppn_i),
    .fill_read_only_i(fill_read_only_i),
    .fill_dirty_i    (fill_dirty_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .phys_addr_o     (phys_addr_o),
    .fill_slot_o     (fill_slot_o),
    .hits_o          (hits_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Applies one request to the shadow TLB and returns the result it must produce.
  function automatic tlb_rsp_t predict_translation(tlb_req_t r);
    tlb_rsp_t            rsp;
    logic [VpnW-1:0]     vpn;
    logic [PageBits-1:0] ofs;
    logic [1:0]          cls;
    logic [1:0]          best_cls;
    int                  hit;
    int                  victim;
    int                  i;
    rsp.status = ST_OK;
    rsp.paddr  = '0;
    rsp.slot   = '0;
    vpn = r.vaddr[AddrW-1:PageBits];
    ofs = r.vaddr[PageBits-1:0];
    if (r.action == ACT_CLEAR_USE) begin
      for (i = 0; i < Entries; i++) slot_use[i] = 1'b0;
    end else if (r.action == ACT_TRANSLATE || r.action == ACT_REFILL) begin
      // Only word and halfword accesses carry an alignment requirement.
      if ((r.size == SizeWord && r.vaddr[1:0] != 2'b00) ||
          (r.size == SizeHalf && r.vaddr[0])) begin
        rsp.status = ST_ALIGN;
      end else if (r.action == ACT_TRANSLATE) begin
        hit = -1;
        for (i = Entries - 1; i >= 0; i--) begin
          if (slot_valid[i] && slot_vpn[i] == vpn) hit = i;
        end
        if (hit < 0) begin
          rsp.status = ST_MISS;
        end else begin
          // A write to a read-only page still counts as a hit.
          hit_total++;
          if (slot_ro[hit] && r.wr) begin
            rsp.status = ST_RO;
          end else begin
            slot_use[hit] = 1'b1;
            if (r.wr) slot_dirty[hit] = 1'b1;
            rsp.paddr = {slot_ppn[hit], ofs};
          end
        end
      end else if (r.ro && r.wr) begin
        rsp.status = ST_RO;
      end else begin
        // Lowest free slot first, then the lowest slot of the lowest use/dirty class.
        victim = -1;
        for (i = Entries - 1; i >= 0; i--) begin
          if (!slot_valid[i]) victim = i;
        end
        if (victim < 0) begin
          victim   = 0;
          best_cls = {slot_use[0], slot_dirty[0]};
          for (i = 1; i < Entries; i++) begin
            cls = {slot_use[i], slot_dirty[i]};
            if (cls < best_cls) begin
              best_cls = cls;
              victim   = i;
            end
          end
        end
        slot_valid[victim] = 1'b1;
        slot_vpn[victim]   = vpn;
        slot_ppn[victim]   = r.ppn;
        slot_ro[victim]    = r.ro;
        slot_use[victim]   = 1'b1;
        slot_dirty[victim] = r.dirty | r.wr;
        rsp.paddr = {r.ppn, ofs};
        rsp.slot  = victim[FslotW-1:0];
      end
    end
    rsp.hits = hit_total;
    return rsp;
  endfunction

  function automatic void add_row(action_e a, logic [AddrW-1:0] va, int sz, bit wr,
                                  logic [PpnW-1:0] ppn, bit ro, bit dt, bit typed = 1'b0,
                                  status_e st = ST_OK, logic [AddrW-1:0] pa = '0,
                                  logic [FslotW-1:0] sl = '0, logic [AddrW-1:0] h = '0);
    dir_row_t row;
    row.req   = '{action: a, vaddr: va, size: SizeW'(sz), wr: wr, ppn: ppn, ro: ro, dirty: dt};
    row.typed = typed;
    row.rsp   = '{status: st, paddr: pa, slot: sl, hits: h};
    dir_rows.push_back(row);
  endfunction

  // Access to the given page with random size, offset, write flag and fill fields.
  function automatic tlb_req_t make_access(action_e act, logic [VpnW-1:0] vpn);
    tlb_req_t            r;
    logic [PageBits-1:0] ofs;
    r.action = act;
    r.size   = SizeW'($urandom_range(1, 4));
    r.wr     = 1'($urandom_range(0, 1));
    r.ppn    = PpnW'($urandom);
    r.ro     = ($urandom_range(0, 4) == 0);
    r.dirty  = ($urandom_range(0, 2) == 0);
    ofs      = PageBits'($urandom);
    // Mostly aligned, so that lookups and refills actually happen.
    if ($urandom_range(0, 9) != 0) begin
      if (r.size == SizeWord) ofs[1:0] = 2'b00;
      else if (r.size == SizeHalf) ofs[0] = 1'b0;
    end
    r.vaddr = {vpn, ofs};
    return r;
  endfunction

  // Drives one request, waits for its transfer and records the result it must give.
  task automatic send_request(input tlb_req_t r, input bit use_typed, input tlb_rsp_t typed,
                              output tlb_rsp_t pred);
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= r.action;
    virt_addr_i      <= r.vaddr;
    access_size_i    <= r.size;
    is_write_i       <= r.wr;
    fill_ppn_i       <= r.ppn;
    fill_read_only_i <= r.ro;
    fill_dirty_i     <= r.dirty;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = predict_translation(r);
    predicted_results.push_back(use_typed ? typed : pred);
    n_sent++;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 11);
  end

  // Each result transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    tlb_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_results.size() == 0) begin
        $error("result transfer with no request outstanding: status %0d", status_o);
        fail_count++;
      end else begin
        want = predicted_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
        if (phys_addr_o !== want.paddr) begin
          $error("phys_addr: expected %h, actual %h", want.paddr, phys_addr_o);
          fail_count++;
        end
        if (fill_slot_o !== want.slot) begin
          $error("fill_slot: expected %0d, actual %0d", want.slot, fill_slot_o);
          fail_count++;
        end
        if (hits_o !== want.hits) begin
          $error("hits: expected %0d, actual %0d", want.hits, hits_o);
          fail_count++;
        end
        n_checked++;
        status_seen[status_o]++;
      end
    end
  end

  // Ends a hung run: too many cycles without a transfer on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no transfer for %0d cycles", quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    tlb_req_t req;
    tlb_req_t last_miss;
    tlb_rsp_t got;
    bit       refill_due;
    int       sel;
    for (int i = 0; i < Entries; i++) begin
      slot_valid[i] = 1'b0;
      slot_vpn[i]   = '0;
      slot_ppn[i]   = '0;
      slot_ro[i]    = 1'b0;
      slot_use[i]   = 1'b0;
      slot_dirty[i] = 1'b0;
    end
    hit_total  = '0;
    refill_due = 1'b0;
    for (int i = 0; i < PoolSize; i++) page_pool[i] = VpnW'($urandom);

    // Empty TLB, alignment errors, extreme pages and offsets.
    add_row(ACT_TRANSLATE, 32'h0000_0000, 1, 0, '0, 0, 0, 1, ST_MISS, '0, '0, 32'd0);
    add_row(ACT_TRANSLATE, 32'hFFFF_FFFF, 4, 0, '1, 1, 1, 1, ST_ALIGN, '0, '0, 32'd0);
    add_row(ACT_TRANSLATE, 32'h0000_0001, 2, 1, '0, 1, 1, 1, ST_ALIGN, '0, '0, 32'd0);
    add_row(ACT_REFILL,    32'h0000_0003, 4, 0, '1, 0, 0, 1, ST_ALIGN, '0, '0, 32'd0);
    add_row(ACT_REFILL,    32'h0000_0000, 4, 0, '1, 0, 0, 1, ST_OK, 32'hFFFF_FF80, 2'd0, 32'd0);
    add_row(ACT_TRANSLATE, 32'h0000_007F, 1, 0, '0, 0, 0, 1, ST_OK, 32'hFFFF_FFFF, 2'd0, 32'd1);
    // A write refill of a read-only entry fills nothing.
    add_row(ACT_REFILL,    32'hFFFF_FFFC, 4, 1, '0, 1, 0, 1, ST_RO, '0, '0, 32'd1);
    add_row(ACT_REFILL,    32'hFFFF_FFFC, 4, 0, '0, 1, 1, 1, ST_OK, 32'h0000_007C, 2'd1, 32'd1);
    // Write hit on a read-only page: counted, but refused.
    add_row(ACT_TRANSLATE, 32'hFFFF_FFFD, 1, 1, '0, 0, 0, 1, ST_RO, '0, '0, 32'd2);
    add_row(ACT_TRANSLATE, 32'hFFFF_FFFE, 2, 0, '0, 0, 0);
    // Size 3 is never misaligned.
    add_row(ACT_REFILL,    32'h1234_567B, 3, 1, 25'h0AAAAAA, 0, 0);
    add_row(ACT_REFILL,    32'h89AB_CDE0, 4, 0, 25'h1555555, 0, 1);
    add_row(ACT_CLEAR_USE, 32'h5555_5555, 4, 1, '1, 1, 1, 1, ST_OK, '0, '0, 32'd3);
    // The unused action code changes nothing and returns an empty result.
    add_row(ACT_NONE,      32'hFFFF_FFFF, 4, 1, '1, 1, 1, 1, ST_OK, '0, '0, 32'd3);
    // Full TLB: the victim comes from the lowest use/dirty class.
    add_row(ACT_REFILL,    32'h0000_1000, 1, 0, 25'h0123456, 0, 0);
    add_row(ACT_TRANSLATE, 32'h0000_0010, 4, 0, '0, 0, 0);
    add_row(ACT_TRANSLATE, 32'h1234_567B, 1, 1, '0, 0, 0);
    add_row(ACT_CLEAR_USE, 32'h0000_0000, 1, 0, '0, 0, 0);
    add_row(ACT_REFILL,    32'h0000_2000, 2, 0, 25'h1FF0000, 0, 0);
    // Refilling a page that is already present leaves a duplicate; the lower slot wins.
    add_row(ACT_REFILL,    32'h1234_5600, 4, 0, 25'h0000F0F, 0, 0);
    add_row(ACT_TRANSLATE, 32'h1234_5604, 4, 0, '0, 0, 0);
    add_row(ACT_TRANSLATE, 32'h89AB_CDE2, 4, 1, '0, 0, 0);
    add_row(ACT_TRANSLATE, 32'h89AB_CDE2, 2, 1, '0, 0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp, got);

    // Random traffic over a small page pool, so that hits, misses and evictions all occur.
    // A miss is usually followed by the refill that completes it.
    for (int n = 0; n < RandomItems; n++) begin
      calm = (n >= 300 && n < 450);
      if (n == 150 || n == 600) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (predicted_results.size() != 0);
      end
      if (n % 200 == 199) page_pool[$urandom_range(0, PoolSize - 1)] = VpnW'($urandom);
      sel = $urandom_range(0, 99);
      if (refill_due && sel < 85) begin
        req        = make_access(ACT_REFILL, last_miss.vaddr[AddrW-1:PageBits]);
        req.vaddr  = last_miss.vaddr;
        req.size   = last_miss.size;
        req.wr     = last_miss.wr;
      end else if (sel < 60) begin
        req = make_access(ACT_TRANSLATE, page_pool[$urandom_range(0, PoolSize - 1)]);
      end else if (sel < 78) begin
        req = make_access(ACT_REFILL, page_pool[$urandom_range(0, PoolSize - 1)]);
      end else if (sel < 88) begin
        req = make_access(ACT_CLEAR_USE, VpnW'($urandom));
      end else begin
        req = make_access(action_e'($urandom_range(0, 3)), VpnW'($urandom));
      end
      send_request(req, 1'b0, '0, got);
      refill_due = (req.action == ACT_TRANSLATE && got.status == ST_MISS);
      if (refill_due) last_miss = req;
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d requests (%0d from the directed table), checked %0d results.",
             n_sent, dir_rows.size(), n_checked);
    $display("Results: ok %0d, misaligned %0d, miss %0d, read-only %0d; final hit count %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], hit_total);
    if (fail_count == 0 && predicted_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tlbn_pkg.sv
src/tlbn_lookup.sv
src/tlbn_victim.sv
src/tlb_translate_nru_refill_unit.sv
dv/tb.sv
